[rtl/aoc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package aoc_pkg;

    localparam int NUM_LANES = 3;
    localparam int DIV_STAGES = 8;
    // weight register, numerator register, then one register per quotient bit
    localparam int PIPE_LAT = DIV_STAGES + 2;

    localparam logic [7:0] FULL_ALPHA = 8'd255;

    localparam logic [1:0] REG_OPACITY = 2'd0;
    localparam logic [1:0] REG_DST_HAS_ALPHA = 2'd1;
    localparam logic [1:0] REG_SRC_HAS_ALPHA = 2'd2;

    typedef struct packed {
        logic [15:0] ws;
        logic [15:0] wd;
        logic [15:0] den;
    } t_wgt;

    typedef logic [NUM_LANES-1:0][7:0] t_color;

    // floor(x / 255) for x up to 65025
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage
`default_nettype wire

[rtl/alpha_over_compositor_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Porter-Duff over compositing of one source pixel onto one destination pixel.
// A pixel pair is taken on every clock where i_start is high (o_busy stays low),
// and its result appears on the o_out_* ports for one cycle with o_valid high,
// after one weight stage, one multiply stage and eight stages of a
// restoring divider that yields one quotient bit each. Three color lanes run side
// by side; the receiver cannot stall, so results must be taken as they come.
// Configuration (opacity at 0x0, dst_has_alpha at 0x4, src_has_alpha at 0x8)
// is written over the APB port and must only change while no pixel is in flight.
module alpha_over_compositor_top import aoc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [7:0]  i_dst_blue,
    input  wire logic [7:0]  i_dst_green,
    input  wire logic [7:0]  i_dst_red,
    input  wire logic [7:0]  i_dst_alpha,
    input  wire logic [7:0]  i_src_blue,
    input  wire logic [7:0]  i_src_green,
    input  wire logic [7:0]  i_src_red,
    input  wire logic [7:0]  i_src_alpha,
    output logic             o_valid,
    output logic [7:0]       o_out_blue,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_alpha
);

    logic [7:0]          r_opacity;
    logic                r_dst_has_alpha;
    logic                r_src_has_alpha;
    logic                cfg_wr;
    logic                accept;
    logic [PIPE_LAT-1:0] r_vld;
    logic [7:0]          r_oa [0:PIPE_LAT-2];
    t_wgt                wgt;
    t_color              dst;
    t_color              src;
    t_color              w_dst;
    t_color              w_src;
    t_color              lane_q;
    logic [NUM_LANES-1:0] lane_zero;

    assign o_pready = 1'b1;
    assign o_busy   = 1'b0;
    assign accept   = i_start && !o_busy;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity       <= FULL_ALPHA;
            r_dst_has_alpha <= 1'b1;
            r_src_has_alpha <= 1'b1;
        end else if (cfg_wr) begin
            unique case (i_paddr[3:2])
                REG_OPACITY:       r_opacity       <= i_pwdata[7:0];
                REG_DST_HAS_ALPHA: r_dst_has_alpha <= i_pwdata[0];
                REG_SRC_HAS_ALPHA: r_src_has_alpha <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            REG_OPACITY:       o_prdata = {24'd0, r_opacity};
            REG_DST_HAS_ALPHA: o_prdata = {31'd0, r_dst_has_alpha};
            REG_SRC_HAS_ALPHA: o_prdata = {31'd0, r_src_has_alpha};
            default:           o_prdata = 32'd0;
        endcase
    end

    assign dst = {i_dst_red, i_dst_green, i_dst_blue};
    assign src = {i_src_red, i_src_green, i_src_blue};

    aoc_weight u_weight (
        .i_clk           (i_clk),
        .i_en            (accept),
        .i_opacity       (r_opacity),
        .i_dst_has_alpha (r_dst_has_alpha),
        .i_src_has_alpha (r_src_has_alpha),
        .i_dst_alpha     (i_dst_alpha),
        .i_src_alpha     (i_src_alpha),
        .i_dst           (dst),
        .i_src           (src),
        .o_wgt           (wgt),
        .o_dst           (w_dst),
        .o_src           (w_src)
    );

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        aoc_lane u_lane (
            .i_clk      (i_clk),
            .i_sc       (w_src[l]),
            .i_dc       (w_dst[l]),
            .i_wgt      (wgt),
            .o_q        (lane_q[l]),
            .o_den_zero (lane_zero[l])
        );
    end

    // output alpha rides alongside the lanes
    always_ff @(posedge i_clk) begin
        r_oa[0] <= div255(wgt.den);
        for (int k = 1; k < PIPE_LAT - 1; k++) begin
            r_oa[k] <= r_oa[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], accept};
        end
    end

    // merge: fully transparent result forces the colors to zero
    assign o_valid     = r_vld[PIPE_LAT-1];
    assign o_out_blue  = lane_zero[0] ? 8'd0 : lane_q[0];
    assign o_out_green = lane_zero[1] ? 8'd0 : lane_q[1];
    assign o_out_red   = lane_zero[2] ? 8'd0 : lane_q[2];
    assign o_out_alpha = r_oa[PIPE_LAT-2];

endmodule
`default_nettype wire

[rtl/aoc_weight.sv]
`timescale 1ns / 1ps
`default_nettype none
module aoc_weight import aoc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [7:0]  i_opacity,
    input  wire logic        i_dst_has_alpha,
    input  wire logic        i_src_has_alpha,
    input  wire logic [7:0]  i_dst_alpha,
    input  wire logic [7:0]  i_src_alpha,
    input  wire t_color      i_dst,
    input  wire t_color      i_src,
    output t_wgt             o_wgt,
    output t_color           o_dst,
    output t_color           o_src
);

    logic [7:0]  sa_in;
    logic [7:0]  da;
    logic [8:0]  sum;
    logic [7:0]  sa;
    logic [15:0] ws;
    logic [15:0] wd;
    t_wgt        n_wgt;
    t_wgt        r_wgt;
    t_color      r_dst;
    t_color      r_src;

    always_comb begin
        sa_in = i_src_has_alpha ? i_src_alpha : FULL_ALPHA;
        da    = i_dst_has_alpha ? i_dst_alpha : FULL_ALPHA;
        sum   = {1'b0, sa_in} + {1'b0, i_opacity};
        sa    = (sum > {1'b0, FULL_ALPHA}) ? 8'(sum - {1'b0, FULL_ALPHA}) : 8'd0;
        ws    = {sa, 8'd0} - {8'd0, sa};
        wd    = {8'd0, da} * {8'd0, 8'(FULL_ALPHA - sa)};
        n_wgt.ws  = ws;
        n_wgt.wd  = wd;
        n_wgt.den = ws + wd;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wgt <= n_wgt;
            r_dst <= i_dst;
            r_src <= i_src;
        end
    end

    assign o_wgt = r_wgt;
    assign o_dst = r_dst;
    assign o_src = r_src;

endmodule
`default_nettype wire

[rtl/aoc_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
module aoc_lane import aoc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic [7:0]  i_sc,
    input  wire logic [7:0]  i_dc,
    input  wire t_wgt        i_wgt,
    output logic [7:0]       o_q,
    output logic             o_den_zero
);

    logic [23:0] prod_s;
    logic [23:0] prod_d;
    logic [23:0] r_rem [0:DIV_STAGES];
    logic [15:0] r_den [0:DIV_STAGES];
    logic [7:0]  r_q   [0:DIV_STAGES];

    assign prod_s = {16'd0, i_sc} * {8'd0, i_wgt.ws};
    assign prod_d = {16'd0, i_dc} * {8'd0, i_wgt.wd};

    always_ff @(posedge i_clk) begin
        r_rem[0] <= prod_s + prod_d;
        r_den[0] <= i_wgt.den;
        r_q[0]   <= 8'd0;
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        logic [23:0] dsh;
        logic        ge;
        assign dsh = {8'd0, r_den[s]} << (DIV_STAGES - 1 - s);
        assign ge  = r_rem[s] >= dsh;
        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= ge ? r_rem[s] - dsh : r_rem[s];
            r_den[s+1] <= r_den[s];
            r_q[s+1]   <= {r_q[s][6:0], ge};
        end
    end

    assign o_q        = r_q[DIV_STAGES];
    assign o_den_zero = (r_den[DIV_STAGES] == 16'd0);

endmodule
`default_nettype wire

[rtl/aoc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module aoc_checker import aoc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       o_busy,
    input  wire logic       o_pready,
    input  wire logic       o_valid,
    input  wire logic [7:0] o_out_alpha
);

    // every result traces back to an earlier transaction taken by the pipe
    a_valid_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, PIPE_LAT))
        else $error("result without matching transaction");

    // a transaction taken while reset stays deasserted yields a result
    a_start_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) ##PIPE_LAT 1'b1 |-> o_valid || !$past(i_rst_n, 1))
        else $error("transaction lost");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy && o_pready)
        else $error("stream stalled");

    a_alpha_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_out_alpha))
        else $error("unknown alpha on result");

endmodule

bind alpha_over_compositor_top aoc_checker u_aoc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_pready    (o_pready),
    .o_valid     (o_valid),
    .o_out_alpha (o_out_alpha)
);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import aoc_pkg::*;

    typedef struct packed {
        logic [7:0] db, dg, dr, da, sb, sg, sr, sa;
    } t_pixpair;

    typedef struct packed {
        logic [7:0] b, g, r, a;
    } t_blend;

    typedef struct {
        t_pixpair px;
        bit       known;
        t_blend   res;
    } t_row;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    t_pixpair    pix;
    logic        valid;
    t_blend      got;

    logic [7:0] m_opacity;
    logic       m_dst_alpha, m_src_alpha;
    t_blend     blend_q[$];
    int         err_count;
    t_row       dir_rows[$];

    alpha_over_compositor_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready),
        .i_start(start), .o_busy(busy),
        .i_dst_blue(pix.db), .i_dst_green(pix.dg), .i_dst_red(pix.dr),
        .i_dst_alpha(pix.da),
        .i_src_blue(pix.sb), .i_src_green(pix.sg), .i_src_red(pix.sr),
        .i_src_alpha(pix.sa),
        .o_valid(valid), .o_out_blue(got.b), .o_out_green(got.g),
        .o_out_red(got.r), .o_out_alpha(got.a)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        err_count++;
        $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
    endtask

    function automatic logic [7:0] mix_lane(input logic [7:0] sc, input logic [7:0] dc,
                                            input int ws, input int wd, input int den);
        int q;
        if (den == 0) return 8'd0;
        q = (sc * ws + dc * wd) / den;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic t_blend composite_over(input t_pixpair p);
        int da, sa_in, sa, ws, wd, den;
        t_blend r;
        da = m_dst_alpha ? int'(p.da) : 255;
        sa_in = m_src_alpha ? int'(p.sa) : 255;
        sa = (sa_in + m_opacity > 255) ? sa_in + m_opacity - 255 : 0;
        ws = sa * 255;
        wd = da * (255 - sa);
        den = ws + wd;
        r.b = mix_lane(p.sb, p.db, ws, wd, den);
        r.g = mix_lane(p.sg, p.dg, ws, wd, den);
        r.r = mix_lane(p.sr, p.dr, ws, wd, den);
        r.a = (den / 255 > 255) ? 8'd255 : 8'(den / 255);
        return r;
    endfunction

    // result checker, strobe sampled at the edge
    always @(posedge clk) begin
        t_blend e;
        if (rst_n && valid) begin
            if (blend_q.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 1);
            end else begin
                e = blend_q.pop_front();
                if (got.b !== e.b) report_mismatch("blue", e.b, got.b);
                if (got.g !== e.g) report_mismatch("green", e.g, got.g);
                if (got.r !== e.r) report_mismatch("red", e.r, got.r);
                if (got.a !== e.a) report_mismatch("alpha", e.a, got.a);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_OPACITY:       m_opacity = val[7:0];
            REG_DST_HAS_ALPHA: m_dst_alpha = val[0];
            REG_SRC_HAS_ALPHA: m_src_alpha = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        while (blend_q.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        repeat (n) @(posedge clk);
    endtask

    // one transaction; start dropped only when a gap follows
    task automatic send_pair(input t_pixpair p, input t_blend e, input bit gap);
        start <= 1'b1;
        pix <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
        blend_q.push_back(e);
        if (gap) begin
            start <= 1'b0;
            @(posedge clk);
            idle_gap();
        end
    endtask

    function automatic t_pixpair rand_pair();
        t_pixpair p;
        p = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: p.sa = 8'd0;
            1: p.sa = 8'd255;
            2: p.da = 8'd0;
            3: begin p.sa = 8'd0; p.da = 8'd0; end
            default: ;
        endcase
        return p;
    endfunction

    task automatic add_row(input t_pixpair p, input bit known, input t_blend r);
        t_row row;
        row.px = p;
        row.known = known;
        row.res = r;
        dir_rows.push_back(row);
    endtask

    initial begin
        t_blend e;
        t_pixpair p;
        bit burst;
        err_count = 0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        start = 1'b0;
        pix = '0;
        m_opacity = 8'd255;
        m_dst_alpha = 1'b1;
        m_src_alpha = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opaque source passes through, transparent over transparent is zero
        add_row('{8'h10, 8'h20, 8'h30, 8'hff, 8'hab, 8'hcd, 8'hef, 8'hff}, 1,
                '{8'hab, 8'hcd, 8'hef, 8'hff});
        add_row('{8'h10, 8'h20, 8'h30, 8'h00, 8'hab, 8'hcd, 8'hef, 8'h00}, 1,
                '{8'h00, 8'h00, 8'h00, 8'h00});
        add_row('{8'h12, 8'h34, 8'h56, 8'hff, 8'hab, 8'hcd, 8'hef, 8'h00}, 1,
                '{8'h12, 8'h34, 8'h56, 8'hff});
        add_row('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 1,
                '{8'hff, 8'hff, 8'hff, 8'hff});
        add_row('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff}, 1,
                '{8'h00, 8'h00, 8'h00, 8'hff});
        add_row('{8'hff, 8'h00, 8'hff, 8'h80, 8'h00, 8'hff, 8'h00, 8'h80}, 0, '0);
        add_row('{8'h55, 8'haa, 8'h55, 8'h01, 8'haa, 8'h55, 8'haa, 8'hfe}, 0, '0);
        add_row('{8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01}, 0, '0);
        foreach (dir_rows[i]) begin
            e = dir_rows[i].known ? dir_rows[i].res : composite_over(dir_rows[i].px);
            send_pair(dir_rows[i].px, e, i[0]);
        end
        start <= 1'b0;
        drain();

        // missing source and destination alpha, opacity zero
        write_reg(REG_DST_HAS_ALPHA, 32'h0);
        write_reg(REG_SRC_HAS_ALPHA, 32'hfffffffe);
        write_reg(REG_OPACITY, 32'h0);
        send_pair('{8'h11, 8'h22, 8'h33, 8'h00, 8'h99, 8'h88, 8'h77, 8'h00},
                  '{8'h11, 8'h22, 8'h33, 8'hff}, 1);
        drain();
        write_reg(REG_OPACITY, 32'hffffff00);
        write_reg(REG_SRC_HAS_ALPHA, 32'h1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_OPACITY, (ph == 0) ? 32'd0 : (ph == 1) ? 32'd255 :
                      (ph == 2) ? 32'd1 : $urandom);
            write_reg(REG_DST_HAS_ALPHA, $urandom);
            write_reg(REG_SRC_HAS_ALPHA, (ph < 4) ? 32'(ph[0]) : $urandom);
            for (int k = 0; k < 62; k++) begin
                p = rand_pair();
                burst = ($urandom_range(0, 3) == 0);
                send_pair(p, composite_over(p), !burst);
            end
            start <= 1'b0;
            drain();
        end

        drain();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
